>>> rtl/bcmc_pkg.sv
// Shared types, codes and the charger command filter for the charge mode controller.
// No dependencies; every other file in rtl/ uses this package by scoped names.
package bcmc_pkg;

   // Charge modes
   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_SLOW = 2'd1;
   localparam logic [1:0] MODE_FAST = 2'd2;
   localparam logic [1:0] MODE_DIS  = 2'd3;
   // Previous-mode register value before any mode was chosen
   localparam logic [2:0] PREV_NONE = 3'd7;

   // Charger commands
   localparam logic [1:0] CMD_DIS  = 2'd0;
   localparam logic [1:0] CMD_SLOW = 2'd1;
   localparam logic [1:0] CMD_FAST = 2'd2;

   // Cable sources
   localparam logic [1:0] SRC_NONE     = 2'd0;
   localparam logic [1:0] SRC_USB      = 2'd1;
   localparam logic [1:0] SRC_AC       = 2'd2;
   localparam logic [1:0] SRC_RESERVED = 2'd3;

   // Level thresholds (percent)
   localparam logic [7:0] LEVEL_NOT_FULL_MAX = 8'd99;
   localparam logic [7:0] LEVEL_FULL         = 8'd100;

   // Configuration register indexes
   localparam logic [2:0] CSR_CRIT_TEMP        = 3'd0;
   localparam logic [2:0] CSR_HOT_TEMP         = 3'd1;
   localparam logic [2:0] CSR_WARM_TEMP        = 3'd2;
   localparam logic [2:0] CSR_HOT_MAX_MV       = 3'd3;
   localparam logic [2:0] CSR_HOT_MIN_MV       = 3'd4;
   localparam logic [2:0] CSR_DISABLE_MIN_MV   = 3'd5;
   localparam logic [2:0] CSR_CHARGE_TIMEOUT_S = 3'd6;
   localparam logic [2:0] CSR_FULL_CURRENT_MA  = 3'd7;

   localparam int CSR_DATA_W = 16;

   typedef struct packed {
      logic signed [11:0] crit_temp;
      logic signed [11:0] hot_temp;
      logic signed [11:0] warm_temp;
      logic [12:0]        hot_max_mv;
      logic [12:0]        hot_min_mv;
      logic [12:0]        disable_min_mv;
      logic [15:0]        charge_timeout_s;
      logic signed [12:0] full_current_ma;
   } cfg_type;

   typedef struct packed {
      logic signed [11:0] temperature;
      logic [12:0]        batt_mv;
      logic [7:0]         level_pct;
      logic               gauge_full_bit;
      logic signed [12:0] avg_current_ma;
      logic [1:0]         source;
      logic               battery_known;
      logic [31:0]        poll_time_s;
   } poll_type;

   // One result transaction, without the per-poll status fields
   typedef struct packed {
      logic [1:0] charger_cmd;
      logic       cmd_valid;
      logic       cc_write;
      logic       cc_enable;
   } item_type;

   // All result transactions of one poll
   typedef struct packed {
      item_type [2:0] item;
      logic [1:0]     last_idx;
      logic [1:0]     mode;
      logic           is_full;
      logic           in_cooldown;
   } bundle_type;

   typedef struct packed {
      logic [1:0] sent;
      logic       ok;
      logic [1:0] prev;
   } send_type;

   // Repeat filter: unknown battery always sends disable; otherwise drop repeats.
   function automatic send_type send_cmd(input logic [1:0] cmd, input logic known,
                                         input logic [1:0] prev);
      send_type s;
      if (!known) begin
         s.sent = CMD_DIS;
         s.ok   = 1'b1;
         s.prev = CMD_DIS;
      end else if (prev == cmd) begin
         s.sent = CMD_DIS;
         s.ok   = 1'b0;
         s.prev = prev;
      end else begin
         s.sent = cmd;
         s.ok   = 1'b1;
         s.prev = cmd;
      end
      return s;
   endfunction

endpackage

>>> rtl/bcmc_csr.sv
// Configuration register file for the charge mode controller.
// Depends on bcmc_pkg (cfg_type, register indexes).
module bcmc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [2:0]                     csr_index,
   input  logic [bcmc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output bcmc_pkg::cfg_type              cfg
);

   bcmc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crit_temp        <= 12'sd600;
         cfg_ff.hot_temp         <= 12'sd500;
         cfg_ff.warm_temp        <= 12'sd450;
         cfg_ff.hot_max_mv       <= 13'd4100;
         cfg_ff.hot_min_mv       <= 13'd3800;
         cfg_ff.disable_min_mv   <= 13'd4100;
         cfg_ff.charge_timeout_s <= 16'd3600;
         cfg_ff.full_current_ma  <= 13'sd40;
      end else if (csr_wr_en) begin
         case (csr_index)
            bcmc_pkg::CSR_CRIT_TEMP:        cfg_ff.crit_temp        <= csr_wdata[11:0];
            bcmc_pkg::CSR_HOT_TEMP:         cfg_ff.hot_temp         <= csr_wdata[11:0];
            bcmc_pkg::CSR_WARM_TEMP:        cfg_ff.warm_temp        <= csr_wdata[11:0];
            bcmc_pkg::CSR_HOT_MAX_MV:       cfg_ff.hot_max_mv       <= csr_wdata[12:0];
            bcmc_pkg::CSR_HOT_MIN_MV:       cfg_ff.hot_min_mv       <= csr_wdata[12:0];
            bcmc_pkg::CSR_DISABLE_MIN_MV:   cfg_ff.disable_min_mv   <= csr_wdata[12:0];
            bcmc_pkg::CSR_CHARGE_TIMEOUT_S: cfg_ff.charge_timeout_s <= csr_wdata[15:0];
            bcmc_pkg::CSR_FULL_CURRENT_MA:  cfg_ff.full_current_ma  <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/bcmc_core.sv
// Mode decision logic and controller state (cooldown, full, last mode/command, seen time).
// Depends on bcmc_pkg; produces the result bundle of one poll per fire.
module bcmc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  bcmc_pkg::poll_type    poll,
   input  bcmc_pkg::cfg_type     cfg,
   output bcmc_pkg::bundle_type  bundle
);

   logic       cooldown_ff, cooldown_in;
   logic       full_ff, full_in;
   logic [2:0] prev_mode_ff, prev_mode_in;
   logic [31:0] seen_ff, seen_in;
   logic [1:0] prev_cmd_ff, prev_cmd_in;

   always_comb begin
      logic [1:0]  mode_w;
      logic [1:0]  en_cmd;
      logic [1:0]  cmd_w;
      logic [1:0]  pc_w;
      logic [32:0] limit_w;
      logic        timeout_w;
      logic        poke_w;
      logic        change_w;
      bcmc_pkg::send_type s0, s1, s2;
      bcmc_pkg::item_type mc_item;

      mode_w = poll.source;
      en_cmd = (poll.source == bcmc_pkg::SRC_AC) ? bcmc_pkg::CMD_FAST : bcmc_pkg::CMD_SLOW;

      // full latch
      full_in = full_ff;
      if (poll.level_pct <= bcmc_pkg::LEVEL_NOT_FULL_MAX) full_in = 1'b0;
      if (poll.gauge_full_bit && (poll.avg_current_ma <= cfg.full_current_ma) &&
          (poll.level_pct == bcmc_pkg::LEVEL_FULL)) begin
         full_in = 1'b1;
         mode_w  = bcmc_pkg::MODE_DIS;
      end

      // thermal handling
      cooldown_in = cooldown_ff;
      if (poll.temperature >= cfg.hot_temp) begin
         if (poll.temperature >= cfg.crit_temp) mode_w = bcmc_pkg::MODE_DIS;
         if (poll.batt_mv >= cfg.hot_max_mv) cooldown_in = 1'b1;
      end
      if ((poll.temperature >= cfg.warm_temp) && (mode_w == bcmc_pkg::MODE_FAST))
         mode_w = bcmc_pkg::MODE_SLOW;
      if (cooldown_in) begin
         if ((poll.temperature < cfg.warm_temp) || (poll.batt_mv <= cfg.hot_min_mv))
            cooldown_in = 1'b0;
         else
            mode_w = bcmc_pkg::MODE_DIS;
      end

      // charge timeout, 33 bits so the sum never wraps
      limit_w   = {1'b0, seen_ff} + {17'd0, cfg.charge_timeout_s};
      timeout_w = {1'b0, poll.poll_time_s} > limit_w;
      poke_w    = 1'b0;
      seen_in   = seen_ff;
      if (full_in) begin
         seen_in = poll.poll_time_s;
      end else if ((prev_mode_ff != {1'b0, bcmc_pkg::MODE_OFF}) && timeout_w) begin
         if (prev_mode_ff == {1'b0, bcmc_pkg::MODE_DIS}) begin
            poke_w  = 1'b1;
            seen_in = poll.poll_time_s;
         end else begin
            mode_w = bcmc_pkg::MODE_OFF;
         end
      end

      if (poll.source == bcmc_pkg::SRC_NONE) mode_w = bcmc_pkg::MODE_OFF;
      if ((mode_w == bcmc_pkg::MODE_DIS) && (poll.batt_mv < cfg.disable_min_mv))
         mode_w = bcmc_pkg::MODE_OFF;

      change_w = prev_mode_ff != {1'b0, mode_w};
      if (change_w && (mode_w != bcmc_pkg::MODE_OFF)) seen_in = poll.poll_time_s;
      prev_mode_in = change_w ? {1'b0, mode_w} : prev_mode_ff;

      // command chain: poke disable, poke enable, mode-change command
      s0   = bcmc_pkg::send_cmd(bcmc_pkg::CMD_DIS, poll.battery_known, prev_cmd_ff);
      s1   = bcmc_pkg::send_cmd(en_cmd, poll.battery_known, s0.prev);
      pc_w = poke_w ? s1.prev : prev_cmd_ff;
      if (mode_w == bcmc_pkg::MODE_OFF)      cmd_w = bcmc_pkg::CMD_DIS;
      else if (mode_w == bcmc_pkg::MODE_DIS) cmd_w = en_cmd;
      else                                   cmd_w = mode_w;
      s2 = bcmc_pkg::send_cmd(cmd_w, poll.battery_known, pc_w);
      prev_cmd_in = change_w ? s2.prev : pc_w;

      mc_item.charger_cmd = s2.sent;
      mc_item.cmd_valid   = s2.ok;
      mc_item.cc_write    = 1'b1;
      mc_item.cc_enable   = mode_w != bcmc_pkg::MODE_DIS;

      bundle = '0;
      if (poke_w) begin
         bundle.item[0] = '{charger_cmd: s0.sent, cmd_valid: s0.ok,
                            cc_write: 1'b0, cc_enable: 1'b0};
         bundle.item[1] = '{charger_cmd: s1.sent, cmd_valid: s1.ok,
                            cc_write: 1'b0, cc_enable: 1'b0};
         if (change_w) begin
            bundle.item[2]  = mc_item;
            bundle.last_idx = 2'd2;
         end else begin
            bundle.last_idx = 2'd1;
         end
      end else begin
         if (change_w) bundle.item[0] = mc_item;
         bundle.last_idx = 2'd0;
      end
      bundle.mode        = mode_w;
      bundle.is_full     = full_in;
      bundle.in_cooldown = cooldown_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cooldown_ff  <= 1'b0;
         full_ff      <= 1'b0;
         prev_mode_ff <= bcmc_pkg::PREV_NONE;
         seen_ff      <= '0;
         prev_cmd_ff  <= bcmc_pkg::CMD_DIS;
      end else if (fire) begin
         cooldown_ff  <= cooldown_in;
         full_ff      <= full_in;
         prev_mode_ff <= prev_mode_in;
         seen_ff      <= seen_in;
         prev_cmd_ff  <= prev_cmd_in;
      end
   end

endmodule

>>> rtl/bcmc_seq.sv
// Result register and item sequencer: holds one poll's bundle and sends its items in order.
// Depends on bcmc_pkg (bundle_type, item_type).
module bcmc_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  bcmc_pkg::bundle_type bundle,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_charger_cmd,
   output logic                 rsp_cmd_valid,
   output logic                 rsp_cc_write,
   output logic                 rsp_cc_enable,
   output logic [1:0]           rsp_mode,
   output logic                 rsp_is_full,
   output logic                 rsp_in_cooldown,
   output logic                 rsp_last_item
);

   bcmc_pkg::bundle_type bundle_ff;
   logic                 valid_ff;
   logic [1:0]           idx_ff;
   logic                 take;
   logic                 last;
   bcmc_pkg::item_type   cur;

   assign last = idx_ff == bundle_ff.last_idx;
   assign take = valid_ff && !rsp_stall;
   assign free = !valid_ff || (take && last);

   always_comb begin
      case (idx_ff)
         2'd0:    cur = bundle_ff.item[0];
         2'd1:    cur = bundle_ff.item[1];
         2'd2:    cur = bundle_ff.item[2];
         default: cur = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (take) begin
         if (last) valid_ff <= 1'b0;
         else      idx_ff   <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) bundle_ff <= bundle;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_charger_cmd = cur.charger_cmd;
   assign rsp_cmd_valid   = cur.cmd_valid;
   assign rsp_cc_write    = cur.cc_write;
   assign rsp_cc_enable   = cur.cc_enable;
   assign rsp_mode        = bundle_ff.mode;
   assign rsp_is_full     = bundle_ff.is_full;
   assign rsp_in_cooldown = bundle_ff.in_cooldown;
   assign rsp_last_item   = last;

   // suppressed or absent commands go out as zero
   a_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cmd_valid |-> rsp_charger_cmd == bcmc_pkg::CMD_DIS)
      else $error("charger_cmd set without cmd_valid");

   a_cc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cc_write |-> !rsp_cc_enable)
      else $error("cc_enable set without cc_write");

   // items of one poll share the status fields
   a_poll_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_item |=>
         rsp_valid && $stable(rsp_mode) && $stable(rsp_is_full) && $stable(rsp_in_cooldown))
      else $error("poll ended without last item or status changed mid-poll");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff <= bundle_ff.last_idx)
      else $error("item index past end of poll");

endmodule

>>> rtl/battery_charge_mode_controller.sv
// Battery charge mode controller, top level.
// Path: input register, core, result register. Throughput: one poll per cycle when
// rsp_stall is low and each poll yields one transaction; a poll with more (timeout
// poke, up to 3) holds the result register until its last transaction is taken.
// Reset (synchronous, active high): config to defaults, flags clear, no mode yet,
// last command disable, seen time 0, both pipeline stages empty.
module battery_charge_mode_controller (
   input  logic                             clock,
   input  logic                             reset,
   // poll input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [11:0]               req_temperature,
   input  logic [12:0]                      req_batt_mv,
   input  logic [7:0]                       req_level_pct,
   input  logic                             req_gauge_full_bit,
   input  logic signed [12:0]               req_avg_current_ma,
   input  logic [1:0]                       req_source,
   input  logic                             req_battery_known,
   input  logic [31:0]                      req_poll_time_s,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_charger_cmd,
   output logic                             rsp_cmd_valid,
   output logic                             rsp_cc_write,
   output logic                             rsp_cc_enable,
   output logic [1:0]                       rsp_mode,
   output logic                             rsp_is_full,
   output logic                             rsp_in_cooldown,
   output logic                             rsp_last_item,
   // configuration write port
   input  logic                             csr_wr_en,
   input  logic [2:0]                       csr_index,
   input  logic [bcmc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bcmc_pkg::cfg_type    cfg;
   bcmc_pkg::poll_type   poll_ff;
   bcmc_pkg::bundle_type bundle;
   logic                 poll_valid_ff;
   logic                 free;
   logic                 advance;
   logic                 accept;

   // Input register: a poll waits here while the result register is busy,
   // so a new transaction can be taken while a result is still stalled.
   assign advance   = poll_valid_ff && free;
   assign req_stall = poll_valid_ff && !free;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
      end else if (accept) begin
         poll_valid_ff <= 1'b1;
      end else if (advance) begin
         poll_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         poll_ff.temperature    <= req_temperature;
         poll_ff.batt_mv        <= req_batt_mv;
         poll_ff.level_pct      <= req_level_pct;
         poll_ff.gauge_full_bit <= req_gauge_full_bit;
         poll_ff.avg_current_ma <= req_avg_current_ma;
         poll_ff.source         <= req_source;
         poll_ff.battery_known  <= req_battery_known;
         poll_ff.poll_time_s    <= req_poll_time_s;
      end
   end

   bcmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // State updates in the same cycle the poll moves into the result register.
   bcmc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .poll   (poll_ff),
      .cfg    (cfg),
      .bundle (bundle)
   );

   bcmc_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .load            (advance),
      .bundle          (bundle),
      .free            (free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_charger_cmd (rsp_charger_cmd),
      .rsp_cmd_valid   (rsp_cmd_valid),
      .rsp_cc_write    (rsp_cc_write),
      .rsp_cc_enable   (rsp_cc_enable),
      .rsp_mode        (rsp_mode),
      .rsp_is_full     (rsp_is_full),
      .rsp_in_cooldown (rsp_in_cooldown),
      .rsp_last_item   (rsp_last_item)
   );

endmodule
